// ===== src/mbtcp_pkg.sv =====
package mbtcp_pkg;

  localparam int SAVED_BYTES = 9;

  typedef enum logic [1:0] {
    WALKING   = 2'd0,
    WALK_PASS = 2'd1,
    WALK_FAIL = 2'd2
  } walk_t;

  localparam logic [7:0] FC_RD_COILS   = 8'h01;
  localparam logic [7:0] FC_RD_DISC    = 8'h02;
  localparam logic [7:0] FC_RD_HOLD    = 8'h03;
  localparam logic [7:0] FC_RD_INPUT   = 8'h04;
  localparam logic [7:0] FC_WR_COIL    = 8'h05;
  localparam logic [7:0] FC_WR_REG     = 8'h06;
  localparam logic [7:0] FC_EXC_STAT   = 8'h07;
  localparam logic [7:0] FC_DIAG       = 8'h08;
  localparam logic [7:0] FC_RSV_09     = 8'h09;
  localparam logic [7:0] FC_RSV_0A     = 8'h0A;
  localparam logic [7:0] FC_COMM_CNT   = 8'h0B;
  localparam logic [7:0] FC_COMM_LOG   = 8'h0C;
  localparam logic [7:0] FC_RSV_0D     = 8'h0D;
  localparam logic [7:0] FC_RSV_0E     = 8'h0E;
  localparam logic [7:0] FC_WR_COILS   = 8'h0F;
  localparam logic [7:0] FC_WR_REGS    = 8'h10;
  localparam logic [7:0] FC_SLAVE_ID   = 8'h11;
  localparam logic [7:0] FC_RD_FILE    = 8'h14;
  localparam logic [7:0] FC_WR_FILE    = 8'h15;
  localparam logic [7:0] FC_MASK_WR    = 8'h16;
  localparam logic [7:0] FC_RW_REGS    = 8'h17;
  localparam logic [7:0] FC_RD_FIFO    = 8'h18;
  localparam logic [7:0] FC_RSV_29     = 8'h29;
  localparam logic [7:0] FC_RSV_2A     = 8'h2A;
  localparam logic [7:0] FC_DEV_ID     = 8'h2B;
  localparam logic [7:0] FC_RSV_5A     = 8'h5A;
  localparam logic [7:0] FC_RSV_5B     = 8'h5B;
  localparam logic [7:0] FC_RSV_7D     = 8'h7D;
  localparam logic [7:0] FC_RSV_7E     = 8'h7E;
  localparam logic [7:0] FC_RSV_7F     = 8'h7F;

  localparam logic [7:0] MEI_BASIC     = 8'h0D;
  localparam logic [7:0] MEI_DEVICE_ID = 8'h0E;

  // diagnostics sub-functions
  localparam logic [15:0] SUB_RESERVED   = 16'd19;
  localparam logic [15:0] SUB_FIRST_FREE = 16'd21;

  typedef logic [7:0] byte_arr_t [SAVED_BYTES];

endpackage

// ===== src/modbus_tcp_pdu_length_checker_top.sv =====
// a packet's last beat is held in the input register, its verdict then in the output register
// throughput: one beat per cycle; all checks are short logic between the input register
//   (pending beat) and the output register, records are walked as bytes stream by
// the input stalls only while a last beat waits behind a verdict the sink has not taken
// reset: rst_n is synchronous, active low; clears counters, walk state and the output valid
module modbus_tcp_pdu_length_checker_top
  import mbtcp_pkg::*;
#(
  parameter int LENGTH_COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // end_of_packet
  input  logic [1:0]  in_tuser,   // start_of_packet, from_client
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // frame_accepted, bad_protocol_id, reserved_function,
                                  // bad_length, unit_id, fcode, 4'b0 pad
);

  localparam int CB = LENGTH_COUNTER_BITS;
  localparam int OB = CB + 1;
  localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};
  localparam logic [CB-1:0] HDR = CB'(8);

  // input register
  logic          v_r;
  logic [7:0]    b_r;
  logic          st_r, en_r, dir_in_r;

  logic [CB-1:0] pos_r, pos_nxt;
  logic          pid_r, pid_nxt;
  logic [7:0]    unit_r, unit_nxt, func_r, func_nxt;
  logic          dir_r, dir_nxt;
  byte_arr_t     p_r, p_nxt;
  logic [OB-1:0] off_r, off_nxt;
  logic [7:0]    rec_r, rec_nxt;
  walk_t         ws_r, ws_nxt;

  logic          ov_r;
  logic [19:0]   od_r;

  logic          stall;
  assign stall = ov_r && !out_tready && v_r && en_r;
  assign in_tready = !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!stall) begin
      v_r <= in_tvalid;
    end
    if (!stall && in_tvalid) begin
      b_r <= in_tdata;
      st_r <= in_tuser[0];
      dir_in_r <= in_tuser[1];
      en_r <= in_tlast;
    end
  end

  logic [CB-1:0] idx, k, dsize, len;
  logic [OB-1:0] rs, tot;
  logic          res_v;
  logic [19:0]   res_d;
  logic          rsv, ok;
  logic [4:0]    m7_a;
  logic [3:0]    m7_b;
  logic          m7_ok;

  always_comb begin
    idx = st_r ? '0 : pos_r;
    pid_nxt = pid_r; unit_nxt = unit_r; func_nxt = func_r; dir_nxt = dir_r;
    p_nxt = p_r; off_nxt = off_r; rec_nxt = rec_r; ws_nxt = ws_r;
    k = idx - HDR;
    rs = '0; tot = '0;
    if (idx == '0) begin
      pid_nxt = 1'b0;
      for (int i = 0; i < SAVED_BYTES; i++) p_nxt[i] = 8'd0;
      off_nxt = '0; rec_nxt = 8'd0; ws_nxt = WALKING; dir_nxt = dir_in_r;
    end
    if ((idx == CB'(2) || idx == CB'(3)) && b_r != 8'd0) pid_nxt = 1'b1;
    else if (idx == CB'(6)) unit_nxt = b_r;
    else if (idx == CB'(7)) func_nxt = b_r;
    if (idx >= HDR) begin
      for (int i = 0; i < SAVED_BYTES; i++)
        if (k == CB'(i)) p_nxt[i] = b_r;
      if (func_r == FC_WR_FILE && dir_r) begin
        tot = OB'(p_r[0]);
        rs = off_r + OB'(1);
        if (k == '0) begin
          off_nxt = '0;
          ws_nxt = (b_r < 8'd7) ? WALK_FAIL : WALKING;
        end else if (ws_r == WALKING) begin
          if (OB'(k) == rs + OB'(5) && b_r != 8'd0) ws_nxt = WALK_FAIL;
          else if (OB'(k) == rs + OB'(6)) begin
            off_nxt = off_r + OB'(7) + OB'({b_r, 1'b0});
            if (off_nxt == tot) ws_nxt = WALK_PASS;
            else if (off_nxt + OB'(7) > tot) ws_nxt = WALK_FAIL;
          end
        end
      end else if (func_r == FC_DEV_ID && !dir_r) begin
        if (k == '0) begin
          off_nxt = OB'(6); rec_nxt = 8'd0;
        end else if (k >= CB'(6) && rec_r < p_r[5] && OB'(k) == off_r + OB'(1)) begin
          off_nxt = off_r + OB'(2) + OB'(b_r);
          rec_nxt = rec_r + 8'd1;
        end
      end
    end
    dsize = (idx == COUNT_MAX) ? COUNT_MAX : idx + CB'(1);
    pos_nxt = en_r ? '0 : dsize;
    len = dsize - HDR;

    rsv = 1'b0;
    case (func_nxt)
      FC_DIAG: rsv = (dsize >= CB'(10)) &&
                     ({p_nxt[0], p_nxt[1]} == SUB_RESERVED ||
                      {p_nxt[0], p_nxt[1]} >= SUB_FIRST_FREE);
      FC_RSV_09, FC_RSV_0A, FC_RSV_0D, FC_RSV_0E, FC_RSV_29, FC_RSV_2A,
      FC_RSV_5A, FC_RSV_5B, FC_RSV_7D, FC_RSV_7E, FC_RSV_7F:
        rsv = 1'b1;
      default: rsv = 1'b0;
    endcase

    // multiple of 7 by octal digit sums, since 8 is 1 mod 7
    m7_a = 5'(p_nxt[0][7:6]) + 5'(p_nxt[0][5:3]) + 5'(p_nxt[0][2:0]);
    m7_b = 4'(m7_a[4:3]) + 4'(m7_a[2:0]);
    m7_ok = (m7_b == 4'd0) || (m7_b == 4'd7);

    ok = 1'b1;
    if (dir_nxt) begin
      case (func_nxt)
        FC_RD_COILS, FC_RD_DISC, FC_RD_HOLD, FC_RD_INPUT, FC_WR_COIL, FC_WR_REG, FC_DIAG:
          ok = len == CB'(4);
        FC_EXC_STAT, FC_COMM_CNT, FC_COMM_LOG, FC_SLAVE_ID: ok = len == '0;
        FC_WR_COILS, FC_WR_REGS:
          ok = len >= CB'(5) && OB'(len) == OB'(p_nxt[4]) + OB'(5);
        FC_MASK_WR: ok = len == CB'(6);
        FC_RW_REGS: ok = len >= CB'(9) && OB'(len) == OB'(p_nxt[8]) + OB'(9);
        FC_RD_FIFO: ok = len == CB'(2);
        FC_DEV_ID: ok = p_nxt[0] == MEI_DEVICE_ID && len == CB'(3);
        FC_RD_FILE: ok = len >= CB'(1) && OB'(p_nxt[0]) == OB'(len - CB'(1)) && m7_ok;
        FC_WR_FILE: ok = len >= CB'(1) && OB'(p_nxt[0]) == OB'(len - CB'(1)) &&
                         ws_nxt == WALK_PASS;
        default: ok = 1'b1;
      endcase
    end else begin
      case (func_nxt)
        FC_RD_COILS, FC_RD_DISC, FC_RD_HOLD, FC_RD_INPUT, FC_COMM_LOG, FC_RW_REGS:
          ok = len >= CB'(1) && OB'(len) == OB'(p_nxt[0]) + OB'(1);
        FC_WR_COIL, FC_WR_REG, FC_DIAG, FC_COMM_CNT, FC_WR_COILS, FC_WR_REGS:
          ok = len == CB'(4);
        FC_EXC_STAT: ok = len == CB'(1);
        FC_MASK_WR: ok = len == CB'(6);
        FC_RD_FIFO: ok = len >= CB'(2) &&
                         17'(len) == 17'({p_nxt[0], p_nxt[1]}) + 17'd2;
        FC_DEV_ID: ok = len >= CB'(6) && (p_nxt[0] == MEI_BASIC ||
                        (p_nxt[0] == MEI_DEVICE_ID && rec_nxt == p_nxt[5] &&
                         off_nxt == OB'(len)));
        default: ok = 1'b1;
      endcase
    end

    res_v = v_r && en_r && dsize >= HDR;
    if (pid_nxt) res_d = {16'd0, 1'b0, 1'b0, 1'b1, 1'b0} ;
    else res_d = {func_nxt, unit_nxt, !ok, rsv, 1'b0, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; pid_r <= 1'b0; unit_r <= 8'd0; func_r <= 8'd0; dir_r <= 1'b0;
      for (int i = 0; i < SAVED_BYTES; i++) p_r[i] <= 8'd0;
      off_r <= '0; rec_r <= 8'd0; ws_r <= WALKING; ov_r <= 1'b0;
    end else begin
      if (v_r && !stall) begin
        pos_r <= pos_nxt; pid_r <= pid_nxt; unit_r <= unit_nxt; func_r <= func_nxt;
        dir_r <= dir_nxt; p_r <= p_nxt; off_r <= off_nxt; rec_r <= rec_nxt;
        ws_r <= ws_nxt;
      end
      if (!stall) begin
        if (res_v) ov_r <= 1'b1;
        else if (out_tready) ov_r <= 1'b0;
      end
    end
    if (!stall && res_v) od_r <= res_d;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {4'd0, od_r};

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(od_r) && ov_r) else $error("result lost under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !ov_r |-> in_tready) else $error("stall with empty output");
  a_pid: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (od_r[0] ^ od_r[1])) else $error("accepted and bad id both set");
`endif

endmodule
